[rtl/core/wsd_pkg.sv]
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared constants and types of the windowed stillness detector.
// ----------------------------------------------------------------------------
package wsd_pkg;

  localparam int unsigned WindowDepth = 1024;
  localparam int unsigned IdxW        = $clog2(WindowDepth);
  localparam int unsigned CntW        = $clog2(WindowDepth + 1);

  localparam int unsigned TimeW = 48;
  localparam int unsigned PosW  = 24;
  localparam int unsigned AngW  = 13;
  localparam int unsigned VelW  = 16;

  // Register indexes.
  localparam logic [2:0] RegEnable  = 3'd0;
  localparam logic [2:0] RegWindow  = 3'd1;
  localparam logic [2:0] RegHorLim  = 3'd2;
  localparam logic [2:0] RegVerLim  = 3'd3;
  localparam logic [2:0] RegHeadLim = 3'd4;
  localparam logic [2:0] RegTiltLim = 3'd5;
  localparam logic [2:0] RegSpeedLim = 3'd6;

  // One ring entry.
  typedef struct packed {
    logic [TimeW-1:0]       t;
    logic signed [PosW-1:0] x;
    logic signed [PosW-1:0] y;
    logic signed [PosW-1:0] z;
    logic signed [AngW-1:0] yaw;
  } entry_t;

endpackage

[rtl/core/wsd_ring.sv]
// ----------------------------------------------------------------------------
// wsd_ring
// Sample ring memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module wsd_ring (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [wsd_pkg::IdxW-1:0]    waddr_i,
  input  wsd_pkg::entry_t             wdata_i,
  input  logic [wsd_pkg::IdxW-1:0]    raddr_i,
  output wsd_pkg::entry_t             rdata_o
);

  wsd_pkg::entry_t mem [wsd_pkg::WindowDepth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[rtl/core/windowed_stillness_detector_core.sv]
// ----------------------------------------------------------------------------
// windowed_stillness_detector_core
// Pose stillness detector over a sliding time window of samples.
// ----------------------------------------------------------------------------
// One sample word is taken at a time. After the sample is written into the
// ring, the oldest entry is read back from the ring memory and dropped while
// older than the window. With the detector enabled, an accepted sample steps
// through the write, read, check, square and output states, with one more
// read and check per aged-out entry, before the next sample is accepted;
// the result word is registered in the output state. The result word is
// held in an output register until taken, and the next sample may be
// accepted meanwhile; the block then waits before its result stage until
// the held word is gone. With the detector disabled a sample is answered
// straight from the idle state, but only while the output register is free
// or being emptied.
module windowed_stillness_detector_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // sample_time, pos_x, pos_y, pos_z, roll_angle, pitch_angle, yaw_angle,
  // vel_x, vel_y, vel_z (lowest first), 208 bits
  input  logic [207:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // is_still, window_full, horizontal_over, vertical_over, heading_over,
  // tilt_recent, speed_recent (lowest first)
  output logic [7:0]  m_axis_tdata_o,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [4:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  localparam int unsigned TW = wsd_pkg::TimeW;
  localparam int unsigned IW = wsd_pkg::IdxW;
  localparam int unsigned CW = wsd_pkg::CntW;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StWrite = 3'd1;
  localparam logic [2:0] StRead  = 3'd2;
  localparam logic [2:0] StCheck = 3'd3;
  localparam logic [2:0] StSq    = 3'd4;
  localparam logic [2:0] StOut   = 3'd5;

  // Configuration.
  logic        en_q;
  logic [31:0] wl_q;
  logic [22:0] hlim_q, vlim_q;
  logic [12:0] alim_q;
  logic [11:0] tlim_q;
  logic [15:0] slim_q;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i;
  assign cfg_idx  = paddr_i[4:2];

  always_comb begin
    case (cfg_idx)
      wsd_pkg::RegEnable:   prdata_o = {31'd0, en_q};
      wsd_pkg::RegWindow:   prdata_o = wl_q;
      wsd_pkg::RegHorLim:   prdata_o = {9'd0, hlim_q};
      wsd_pkg::RegVerLim:   prdata_o = {9'd0, vlim_q};
      wsd_pkg::RegHeadLim:  prdata_o = {19'd0, alim_q};
      wsd_pkg::RegTiltLim:  prdata_o = {20'd0, tlim_q};
      wsd_pkg::RegSpeedLim: prdata_o = {16'd0, slim_q};
      default:              prdata_o = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b0; wl_q <= 32'd1000000; hlim_q <= 23'd100; vlim_q <= 23'd100;
      alim_q <= 13'd50; tlim_q <= 12'd100; slim_q <= 16'd100;
    end else if (cfg_wr) begin
      case (cfg_idx)
        wsd_pkg::RegEnable:   en_q <= pwdata_i[0];
        wsd_pkg::RegWindow:   wl_q <= pwdata_i;
        wsd_pkg::RegHorLim:   hlim_q <= pwdata_i[22:0];
        wsd_pkg::RegVerLim:   vlim_q <= pwdata_i[22:0];
        wsd_pkg::RegHeadLim:  alim_q <= pwdata_i[12:0];
        wsd_pkg::RegTiltLim:  tlim_q <= pwdata_i[11:0];
        wsd_pkg::RegSpeedLim: slim_q <= pwdata_i[15:0];
        default: ;
      endcase
    end
  end

  // Input fields.
  logic [TW-1:0]       in_t;
  logic signed [23:0]  in_x, in_y, in_z;
  logic signed [12:0]  in_roll, in_pitch, in_yaw;
  logic signed [15:0]  in_vx, in_vy, in_vz;
  assign in_t     = s_axis_tdata_i[47:0];
  assign in_x     = s_axis_tdata_i[71:48];
  assign in_y     = s_axis_tdata_i[95:72];
  assign in_z     = s_axis_tdata_i[119:96];
  assign in_roll  = s_axis_tdata_i[132:120];
  assign in_pitch = s_axis_tdata_i[145:133];
  assign in_yaw   = s_axis_tdata_i[158:146];
  assign in_vx    = s_axis_tdata_i[174:159];
  assign in_vy    = s_axis_tdata_i[190:175];
  assign in_vz    = s_axis_tdata_i[206:191];

  // Control and window state.
  logic [2:0]    st_q, st_d;
  logic [IW-1:0] old_q, new_q;
  logic [CW-1:0] cnt_q;
  logic          filled_q, seen_q;
  logic [TW-1:0] ltilt_q, lspeed_q;
  logic          ovalid_q;
  logic [6:0]    odata_q;

  // Per-sample work registers (payload).
  wsd_pkg::entry_t cur_q;
  logic            tviol_q;
  logic [15:0]     vabs_q [3];
  logic            sviol_q;
  logic signed [24:0] dx_q, dy_q, dz_q;
  logic signed [13:0] dyaw_q;
  logic [47:0]     sqx_q, sqy_q, lim2_q;
  logic [31:0]     sql_q;

  logic          accept;
  logic          out_take;
  logic          out_busy;
  logic          res_set;
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_take = m_axis_tvalid_o && m_axis_tready_i;
  assign out_busy = ovalid_q && !m_axis_tready_i;
  assign s_axis_tready_o = (st_q == StIdle) && (en_q || !out_busy);
  assign res_set  = ((st_q == StIdle) && accept && !en_q) ||
                    ((st_q == StOut) && !out_busy);

  // Ring.
  logic            ring_we;
  logic [IW-1:0]   ring_wa, ring_ra;
  wsd_pkg::entry_t ring_rd, ring_wd;

  wsd_ring u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_wa),
    .wdata_i (ring_wd),
    .raddr_i (ring_ra),
    .rdata_o (ring_rd)
  );

  function automatic logic [IW-1:0] nxt(input logic [IW-1:0] i);
    nxt = (i == IW'(wsd_pkg::WindowDepth - 1)) ? '0 : i + 1'b1;
  endfunction

  // Push location computed from state at accept.
  logic          full_now;
  logic [IW-1:0] old_push, new_push;
  assign full_now = cnt_q >= CW'(wsd_pkg::WindowDepth);
  assign old_push = full_now ? nxt(old_q) : old_q;
  assign new_push = (cnt_q == '0) ? old_push : nxt(new_q);

  assign ring_we = (st_q == StWrite);
  assign ring_wa = new_q;
  assign ring_wd = cur_q;
  assign ring_ra = old_q;

  // Age check on the oldest entry read back.
  logic signed [TW:0] age;
  logic               age_out;
  logic signed [13:0] dyaw;
  assign age     = $signed({1'b0, cur_q.t}) - $signed({1'b0, ring_rd.t});
  assign age_out = (cnt_q > CW'(1)) && (age > $signed({17'd0, wl_q}));

  logic [TW-1:0]      tsel_lt, tsel_ls;
  logic signed [TW:0] dt_t, dt_s;
  logic               tilt_r, speed_r, hor, ver, head;
  logic [31:0]        vsq0, vsq1, vsq2;
  logic [33:0]        v2;
  logic [45:0]        hsq;
  logic signed [49:0] sqx, sqy;
  logic [24:0]        adz;
  logic [13:0]        adyaw;
  assign tsel_lt = tviol_q ? cur_q.t : ltilt_q;
  assign tsel_ls = sviol_q ? cur_q.t : lspeed_q;
  assign dt_t    = $signed({1'b0, cur_q.t}) - $signed({1'b0, tsel_lt});
  assign dt_s    = $signed({1'b0, cur_q.t}) - $signed({1'b0, tsel_ls});
  assign tilt_r  = dt_t < $signed({17'd0, wl_q});
  assign speed_r = dt_s < $signed({17'd0, wl_q});
  assign hor     = ({1'b0, sqx_q} + {1'b0, sqy_q}) > {1'b0, lim2_q};
  assign adz     = dz_q[24] ? 25'(-dz_q) : 25'(dz_q);
  assign ver     = adz > {2'b0, vlim_q};
  assign adyaw   = dyaw_q[13] ? 14'(-dyaw_q) : 14'(dyaw_q);
  assign head    = adyaw > {1'b0, alim_q};
  assign vsq0    = vabs_q[0] * vabs_q[0];
  assign vsq1    = vabs_q[1] * vabs_q[1];
  assign vsq2    = vabs_q[2] * vabs_q[2];
  assign v2      = {2'b0, vsq0} + {2'b0, vsq1} + {2'b0, vsq2};
  assign hsq     = hlim_q * hlim_q;
  assign sqx     = dx_q * dx_q;
  assign sqy     = dy_q * dy_q;
  assign dyaw    = 14'(cur_q.yaw) - 14'(ring_rd.yaw);

  function automatic logic [15:0] av(input logic signed [15:0] v);
    av = v[15] ? 16'(-v) : v;
  endfunction
  function automatic logic [12:0] aa(input logic signed [12:0] v);
    aa = v[12] ? 13'(-v) : v;
  endfunction

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle:  if (accept && en_q) st_d = StWrite;
      StWrite: st_d = StRead;
      StRead:  st_d = StCheck;
      StCheck: st_d = age_out ? StRead : StSq;
      StSq:    st_d = StOut;
      StOut:   st_d = out_busy ? StOut : StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (res_set) begin
      ovalid_q <= 1'b1;
    end else if (out_take) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; old_q <= '0; new_q <= '0; cnt_q <= '0;
      filled_q <= 1'b0; seen_q <= 1'b0; ltilt_q <= '0; lspeed_q <= '0;
      odata_q <= '0;
    end else begin
      st_q <= st_d;
      if (cfg_wr && cfg_idx == wsd_pkg::RegEnable) begin
        old_q <= '0; new_q <= '0; cnt_q <= '0;
        filled_q <= 1'b0; seen_q <= 1'b0; ltilt_q <= '0; lspeed_q <= '0;
      end
      case (st_q)
        StIdle: begin
          if (accept && !en_q) begin
            odata_q  <= {5'd0, filled_q, 1'b0};
          end else if (accept) begin
            old_q <= old_push;
            new_q <= new_push;
            cnt_q <= (full_now ? cnt_q : cnt_q + 1'b1);
            if (!seen_q) begin
              seen_q <= 1'b1; ltilt_q <= in_t; lspeed_q <= in_t;
            end
          end
        end
        StCheck: begin
          if (age_out) begin
            old_q <= nxt(old_q); cnt_q <= cnt_q - 1'b1; filled_q <= 1'b1;
          end
        end
        StOut: begin
          if (!out_busy) begin
            if (tviol_q) ltilt_q <= cur_q.t;
            if (sviol_q) lspeed_q <= cur_q.t;
            odata_q  <= {speed_r, tilt_r, head, ver, hor, filled_q,
                         filled_q && !hor && !ver && !head && !tilt_r && !speed_r};
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_q   <= '{t: in_t, x: in_x, y: in_y, z: in_z, yaw: in_yaw};
      tviol_q <= (aa(in_roll) > {1'b0, tlim_q}) || (aa(in_pitch) > {1'b0, tlim_q});
      vabs_q[0] <= av(in_vx); vabs_q[1] <= av(in_vy); vabs_q[2] <= av(in_vz);
    end
    if (st_q == StWrite) begin
      sviol_q <= 1'b0;
      sql_q   <= slim_q * slim_q;
      lim2_q  <= {2'b0, hsq};
    end
    if (st_q == StRead) begin
      sviol_q <= v2 > {2'b0, sql_q};
    end
    if (st_q == StCheck) begin
      dx_q   <= 25'(cur_q.x) - 25'(ring_rd.x);
      dy_q   <= 25'(cur_q.y) - 25'(ring_rd.y);
      dz_q   <= 25'(cur_q.z) - 25'(ring_rd.z);
      dyaw_q <= dyaw;
    end
    if (st_q == StSq) begin
      sqx_q <= sqx[47:0];
      sqy_q <= sqy[47:0];
    end
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {1'b0, odata_q};

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(wsd_pkg::WindowDepth)) else $error("entry count overflow");
  a_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !m_axis_tready_i) |=> ovalid_q && $stable(odata_q))
    else $error("result lost");
  a_filled_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q && !cfg_wr |=> filled_q) else $error("filled flag dropped");
`endif

endmodule

[test/tb_windowed_stillness_detector_core.sv]
// ----------------------------------------------------------------------------
// tb_windowed_stillness_detector_core
// Self-checking bench for the windowed stillness detector core.
// ----------------------------------------------------------------------------
// Pose sample words go in through the sample stream and flag words come back
// on the result stream. A behavioral copy of the detector, with its own ring,
// violation times and register shadow, predicts every flag word. The run
// steps through several register settings (extremes included), with short
// directed bursts in some and long runs of slowly drifting random samples
// in most. Both stream sides idle in random bursts except in the final phase.
module tb_windowed_stillness_detector_core;

  localparam int unsigned Depth = wsd_pkg::WindowDepth;
  localparam int unsigned BufDepth = 1024;

  typedef struct packed {
    logic [15:0]               vz;
    logic [15:0]               vy;
    logic [15:0]               vx;
    logic [wsd_pkg::AngW-1:0]  yaw;
    logic [wsd_pkg::AngW-1:0]  pitch;
    logic [wsd_pkg::AngW-1:0]  roll;
    logic [wsd_pkg::PosW-1:0]  z;
    logic [wsd_pkg::PosW-1:0]  y;
    logic [wsd_pkg::PosW-1:0]  x;
    logic [wsd_pkg::TimeW-1:0] t;
  } sample_t;

  typedef struct packed {
    logic speed_recent;
    logic tilt_recent;
    logic heading_over;
    logic vertical_over;
    logic horizontal_over;
    logic window_full;
    logic is_still;
  } flags_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [207:0] s_axis_tdata_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [7:0]   m_axis_tdata_o;
  logic         psel_i = 1'b0;
  logic         penable_i = 1'b0;
  logic         pwrite_i = 1'b0;
  logic [4:0]   paddr_i = '0;
  logic [31:0]  pwdata_i = '0;
  logic [31:0]  prdata_o;
  logic         pready_o;

  windowed_stillness_detector_core i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state.
  logic [wsd_pkg::TimeW-1:0] ring_t   [Depth];
  logic signed [63:0]    ring_x   [Depth];
  logic signed [63:0]    ring_y   [Depth];
  logic signed [63:0]    ring_z   [Depth];
  logic signed [63:0]    ring_yaw [Depth];
  int unsigned           head_idx, tail_idx, fill_cnt;
  bit                    aged_once, seen_first;
  logic [wsd_pkg::TimeW-1:0] tilt_time, speed_time;
  logic [31:0]           cfg [7];

  // Pending samples and expected flag words, each a simple FIFO by index.
  sample_t     pend_mem [BufDepth];
  int unsigned pend_rd = 0;
  int unsigned pend_wr = 0;
  flags_t      exp_mem [BufDepth];
  int unsigned exp_rd = 0;
  int unsigned exp_wr = 0;
  bit          sample_taken = 1'b0;

  int      mismatches = 0;
  int      results_seen = 0;
  int      still_seen = 0;
  bit      quiet = 1'b0;
  logic [wsd_pkg::TimeW-1:0] clock_us;

  function automatic logic signed [63:0] mag(logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic void clear_detector();
    head_idx = 0;
    tail_idx = 0;
    fill_cnt = 0;
    aged_once = 1'b0;
    seen_first = 1'b0;
    tilt_time = '0;
    speed_time = '0;
  endfunction

  function automatic void queue_sample(sample_t s);
    pend_mem[pend_wr] = s;
    pend_wr++;
  endfunction

  function automatic flags_t judge_sample(sample_t s);
    flags_t f;
    logic signed [63:0] tt, wl, dx, dy, dz, dyaw, vx, vy, vz, roll, pitch;
    logic [63:0] h2, v2;
    f = '0;
    if (!cfg[wsd_pkg::RegEnable][0]) begin
      f.window_full = aged_once;
      return f;
    end
    tt = {16'd0, s.t};
    wl = {32'd0, cfg[wsd_pkg::RegWindow]};
    if (!seen_first) begin
      seen_first = 1'b1;
      tilt_time = s.t;
      speed_time = s.t;
    end
    if (fill_cnt >= Depth) begin
      tail_idx = (tail_idx + 1) % Depth;
      fill_cnt--;
    end
    head_idx = (fill_cnt == 0) ? tail_idx : (head_idx + 1) % Depth;
    ring_t[head_idx] = s.t;
    ring_x[head_idx] = $signed(s.x);
    ring_y[head_idx] = $signed(s.y);
    ring_z[head_idx] = $signed(s.z);
    ring_yaw[head_idx] = $signed(s.yaw);
    fill_cnt++;
    while (fill_cnt > 1 && tt - $signed({16'd0, ring_t[tail_idx]}) > wl) begin
      tail_idx = (tail_idx + 1) % Depth;
      fill_cnt--;
      aged_once = 1'b1;
    end
    roll = $signed(s.roll);
    pitch = $signed(s.pitch);
    if (mag(roll) > cfg[wsd_pkg::RegTiltLim] || mag(pitch) > cfg[wsd_pkg::RegTiltLim])
      tilt_time = s.t;
    vx = $signed(s.vx);
    vy = $signed(s.vy);
    vz = $signed(s.vz);
    v2 = vx * vx + vy * vy + vz * vz;
    if (v2 > 64'(cfg[wsd_pkg::RegSpeedLim]) * cfg[wsd_pkg::RegSpeedLim])
      speed_time = s.t;
    dx = ring_x[head_idx] - ring_x[tail_idx];
    dy = ring_y[head_idx] - ring_y[tail_idx];
    dz = ring_z[head_idx] - ring_z[tail_idx];
    dyaw = ring_yaw[head_idx] - ring_yaw[tail_idx];
    h2 = dx * dx + dy * dy;
    f.horizontal_over = h2 > 64'(cfg[wsd_pkg::RegHorLim]) * cfg[wsd_pkg::RegHorLim];
    f.vertical_over = mag(dz) > cfg[wsd_pkg::RegVerLim];
    f.heading_over = mag(dyaw) > cfg[wsd_pkg::RegHeadLim];
    f.tilt_recent = tt - $signed({16'd0, tilt_time}) < wl;
    f.speed_recent = tt - $signed({16'd0, speed_time}) < wl;
    f.window_full = aged_once;
    f.is_still = aged_once && !f.horizontal_over && !f.vertical_over &&
                 !f.heading_over && !f.tilt_recent && !f.speed_recent;
    return f;
  endfunction

  // Sample driver.
  int src_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (sample_taken) begin
        sample_taken = 1'b0;
        if (!quiet && $urandom_range(0, 9) == 0) src_gap = $urandom_range(1, 12);
      end
      if (src_gap > 0) begin
        src_gap--;
        s_axis_tvalid_i <= 1'b0;
      end else if (pend_rd < pend_wr) begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i <= 208'(pend_mem[pend_rd]);
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // Result side stall.
  int sink_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (sink_gap > 0) begin
        sink_gap--;
        m_axis_tready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        sink_gap = $urandom_range(0, 11);
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Monitor: predict on sample acceptance, check on result acceptance.
  always @(posedge clk_i) begin
    flags_t got, want;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        exp_mem[exp_wr] = judge_sample(sample_t'(s_axis_tdata_i[206:0]));
        exp_wr++;
        pend_rd++;
        sample_taken = 1'b1;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = flags_t'(m_axis_tdata_o[6:0]);
        results_seen++;
        if (got.is_still) still_seen++;
        if (exp_rd == exp_wr) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %b", got);
        end else begin
          want = exp_mem[exp_rd];
          exp_rd++;
          if (got !== want || m_axis_tdata_o[7] !== 1'b0) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected %b got %b", results_seen, want, got);
          end
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(negedge clk_i);
    psel_i <= 1'b1;
    pwrite_i <= 1'b1;
    paddr_i <= {idx, 2'b00};
    pwdata_i <= value;
    @(negedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    while (!pready_o) @(posedge clk_i);
    cfg[idx] = value;
    if (idx == wsd_pkg::RegEnable) clear_detector();
    @(negedge clk_i);
    psel_i <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i <= 1'b0;
  endtask

  task automatic drain();
    while (pend_rd != pend_wr || exp_rd != exp_wr) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic sample_t calm_sample(logic [wsd_pkg::TimeW-1:0] t);
    sample_t s;
    s.t = t;
    s.x = wsd_pkg::PosW'($urandom_range(0, 40)) - wsd_pkg::PosW'(20);
    s.y = wsd_pkg::PosW'($urandom_range(0, 40)) - wsd_pkg::PosW'(20);
    s.z = wsd_pkg::PosW'($urandom_range(0, 40)) - wsd_pkg::PosW'(20);
    s.roll = wsd_pkg::AngW'($urandom_range(0, 60)) - wsd_pkg::AngW'(30);
    s.pitch = wsd_pkg::AngW'($urandom_range(0, 60)) - wsd_pkg::AngW'(30);
    s.yaw = wsd_pkg::AngW'($urandom_range(0, 40)) - wsd_pkg::AngW'(20);
    s.vx = 16'($urandom_range(0, 60)) - 16'd30;
    s.vy = 16'($urandom_range(0, 60)) - 16'd30;
    s.vz = 16'($urandom_range(0, 60)) - 16'd30;
    return s;
  endfunction

  function automatic sample_t wild_sample(logic [wsd_pkg::TimeW-1:0] t);
    sample_t s;
    s = calm_sample(t);
    s.x = wsd_pkg::PosW'($urandom);
    s.y = wsd_pkg::PosW'($urandom);
    s.z = wsd_pkg::PosW'($urandom);
    s.roll = wsd_pkg::AngW'($urandom_range(0, 6284)) - wsd_pkg::AngW'(3142);
    s.pitch = wsd_pkg::AngW'($urandom_range(0, 6284)) - wsd_pkg::AngW'(3142);
    s.yaw = wsd_pkg::AngW'($urandom_range(0, 6284)) - wsd_pkg::AngW'(3142);
    s.vx = 16'($urandom);
    s.vy = 16'($urandom);
    s.vz = 16'($urandom);
    return s;
  endfunction

  task automatic random_phase(int count, int unsigned step_max);
    sample_t s;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 19))
        0: clock_us = clock_us - $urandom_range(0, 50);      // time steps backwards
        1: clock_us = clock_us + 48'({$urandom, $urandom});  // large jump
        default: clock_us = clock_us + $urandom_range(0, step_max);
      endcase
      s = ($urandom_range(0, 9) == 0) ? wild_sample(clock_us) : calm_sample(clock_us);
      queue_sample(s);
    end
  endtask

  task automatic directed_phase();
    sample_t s;
    s = calm_sample(clock_us);
    queue_sample(s);
    s.t = clock_us + 1;                 // same position, just inside window
    queue_sample(s);
    s = '0;
    s.t = clock_us + 5;
    s.x = 24'h7fffff; s.y = 24'h800000; s.z = 24'h7fffff;
    s.roll = 13'd3142; s.pitch = -13'sd3142; s.yaw = 13'd3142;
    s.vx = 16'h8000; s.vy = 16'h7fff; s.vz = 16'h8000;
    queue_sample(s);
    s.t = clock_us + 3;                 // older than its predecessor
    s.x = 24'h800000; s.y = 24'h7fffff; s.z = 24'h800000;
    s.roll = -13'sd3142; s.pitch = 13'd3142; s.yaw = -13'sd3142;
    s.vx = 16'h7fff; s.vy = 16'h8000; s.vz = 16'h7fff;
    queue_sample(s);
    for (int i = 0; i < 8; i++) begin
      s = calm_sample(clock_us + 10 + 2000000 * i);
      queue_sample(s);
    end
    clock_us = clock_us + 16000000;
  endtask

  initial begin
    for (int i = 0; i < 7; i++) cfg[i] = 32'd0;
    cfg[wsd_pkg::RegWindow] = 1000000;
    cfg[wsd_pkg::RegHorLim] = 100;
    cfg[wsd_pkg::RegVerLim] = 100;
    cfg[wsd_pkg::RegHeadLim] = 50;
    cfg[wsd_pkg::RegTiltLim] = 100;
    cfg[wsd_pkg::RegSpeedLim] = 100;
    clear_detector();
    clock_us = 48'd1000;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Disabled: samples pass with only the fill flag reported.
    directed_phase();
    drain();

    write_reg(wsd_pkg::RegEnable, 32'd1);
    directed_phase();
    random_phase(150, 300000);
    drain();

    // Tight limits and a short window.
    write_reg(wsd_pkg::RegWindow, 32'd1000);
    write_reg(wsd_pkg::RegHorLim, 32'd1);
    write_reg(wsd_pkg::RegVerLim, 32'd1);
    write_reg(wsd_pkg::RegHeadLim, 32'd1);
    write_reg(wsd_pkg::RegTiltLim, 32'd1);
    write_reg(wsd_pkg::RegSpeedLim, 32'd1);
    write_reg(wsd_pkg::RegEnable, 32'd1);
    directed_phase();
    random_phase(150, 400);
    drain();

    // Zero window length: only strictly older entries age out.
    write_reg(wsd_pkg::RegWindow, 32'd0);
    write_reg(wsd_pkg::RegEnable, 32'd1);
    random_phase(100, 3);
    drain();

    // Loose limits at their ceilings with a very long window.
    write_reg(wsd_pkg::RegWindow, 32'hffffffff);
    write_reg(wsd_pkg::RegHorLim, 32'h7fffff);
    write_reg(wsd_pkg::RegVerLim, 32'h7fffff);
    write_reg(wsd_pkg::RegHeadLim, 32'd6284);
    write_reg(wsd_pkg::RegTiltLim, 32'd3142);
    write_reg(wsd_pkg::RegSpeedLim, 32'd56756);
    write_reg(wsd_pkg::RegEnable, 32'd1);
    random_phase(200, 10);
    drain();

    // Moderate limits that let the vehicle read as still.
    write_reg(wsd_pkg::RegWindow, 32'd20000);
    write_reg(wsd_pkg::RegHorLim, 32'd60);
    write_reg(wsd_pkg::RegVerLim, 32'd40);
    write_reg(wsd_pkg::RegHeadLim, 32'd40);
    write_reg(wsd_pkg::RegTiltLim, 32'd35);
    write_reg(wsd_pkg::RegSpeedLim, 32'd60);
    write_reg(wsd_pkg::RegEnable, 32'd1);
    random_phase(150, 3000);
    drain();

    // Final phase at full rate, then disable once more.
    quiet = 1'b1;
    random_phase(100, 3000);
    drain();
    write_reg(wsd_pkg::RegEnable, 32'd0);
    random_phase(20, 3000);
    drain();

    $display("Checked %0d result words across seven register settings, %0d of them still.",
             results_seen, still_seen);
    if (mismatches == 0 && exp_rd == exp_wr) begin
      $display("tb_windowed_stillness_detector_core passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb_windowed_stillness_detector_core failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout");
    $display("tb_windowed_stillness_detector_core failed");
    $finish;
  end

endmodule
